// ----- rtl/hat_pkg.sv -----
// Shared types and constants for the handle allocation table.
`default_nettype none
package hat_pkg;

    localparam int HAT_SLOT_COUNT = 32;
    localparam int HAT_PRESET_SLOTS = 3;

    typedef enum logic [2:0] {
        OP_OPEN     = 3'd0,
        OP_CLOSE    = 3'd1,
        OP_LOOKUP   = 3'd2,
        OP_ADD_USER = 3'd3,
        OP_DEL_USER = 3'd4
    } t_hat_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_OPEN = 2'd2
    } t_hat_status;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  slot_handle;
        logic [15:0] external_descriptor;
    } t_hat_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  granted_handle;
        logic [15:0] found_descriptor;
        logic [7:0]  user_count;
    } t_hat_rsp;

    // Decision of the slot control for one request.
    typedef struct packed {
        logic [1:0] status;
        logic [4:0] granted;
        logic [7:0] users;
        logic       wr_en;
        logic       rd_en;
    } t_hat_dec;

endpackage
`default_nettype wire

// ----- rtl/handle_allocation_table.sv -----
// Handle allocation table: slot bitmap allocator with descriptor memory.
// The result strobe o_done is registered through r_pend and then r_done after the start transfer.
// A new request is not taken while busy; busy covers the descriptor memory read.
// Results are shown for exactly one cycle; the receiver cannot stall.
// Reset (synchronous, active low): slots 0..2 open holding 0..2, user count zero.
`default_nettype none
module handle_allocation_table #(
    parameter int SLOT_COUNT = hat_pkg::HAT_SLOT_COUNT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire hat_pkg::t_hat_req i_req,
    output logic                   o_done,
    output hat_pkg::t_hat_rsp      o_rsp
);
    import hat_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);

    logic          accept;
    t_hat_dec      dec;
    logic [SW-1:0] idx;
    logic [15:0]   rd_data;

    // Pending stage: holds the decision while the memory read completes.
    logic       r_pend;
    logic [1:0] r_pend_status;
    logic [4:0] r_pend_granted;
    logic [7:0] r_pend_users;
    logic       r_pend_found;

    // Output stage.
    logic     r_done;
    t_hat_rsp r_rsp;

    assign busy   = r_pend;
    assign accept = start && !busy;

    hat_slot_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .SW         (SW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .o_dec    (dec),
        .o_idx    (idx)
    );

    // Writes land at the accept edge; busy holds off the next accepted request until the
    // memory read has completed, so no forwarding is needed.
    hat_desc_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .SW         (SW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept && dec.wr_en),
        .i_rd_en   (accept && dec.rd_en),
        .i_addr    (idx),
        .i_wr_data (i_req.external_descriptor),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_pend <= accept;
            r_done <= r_pend;
        end
    end

    // Capture the decision on the transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_status  <= dec.status;
            r_pend_granted <= dec.granted;
            r_pend_users   <= dec.users;
            r_pend_found   <= dec.rd_en;
        end
    end

    // Merge the read data and drive the result registers.
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_rsp.status           <= r_pend_status;
            r_rsp.granted_handle   <= r_pend_granted;
            r_rsp.found_descriptor <= r_pend_found ? rd_data : 16'd0;
            r_rsp.user_count       <= r_pend_users;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
`default_nettype wire

// ----- rtl/hat_slot_ctrl.sv -----
// Valid bitmap, lowest-free-slot search and user count.
`default_nettype none
module hat_slot_ctrl #(
    parameter int SLOT_COUNT = 32,
    parameter int SW         = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire hat_pkg::t_hat_req i_req,
    output hat_pkg::t_hat_dec      o_dec,
    output logic [SW-1:0]          o_idx
);
    import hat_pkg::*;

    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic [7:0]            r_users, n_users;
    logic [SW-1:0]         free_idx;
    logic                  free_found;
    logic                  in_range;
    logic                  hit;
    logic [SW-1:0]         h_idx;

    // Lowest clear bit of the bitmap; scan downward so the lowest wins.
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx   = SW'(i);
                free_found = 1'b1;
            end
        end
    end

    assign h_idx    = i_req.slot_handle[SW-1:0];
    assign in_range = {1'b0, i_req.slot_handle} < 9'(SLOT_COUNT);
    assign hit      = in_range && r_valid[h_idx];

    always_comb begin
        n_valid      = r_valid;
        n_users      = r_users;
        o_dec.status = ST_OK;
        o_dec.granted = '0;
        o_dec.wr_en  = 1'b0;
        o_dec.rd_en  = 1'b0;
        o_idx        = h_idx;
        unique case (i_req.operation)
            OP_OPEN: begin
                o_idx = free_idx;
                if (free_found) begin
                    n_valid[free_idx] = 1'b1;
                    o_dec.granted     = 5'(free_idx);
                    o_dec.wr_en       = 1'b1;
                end else begin
                    o_dec.status = ST_FULL;
                end
            end
            OP_CLOSE: begin
                if (hit) begin
                    n_valid[h_idx] = 1'b0;
                end else begin
                    o_dec.status = ST_NOT_OPEN;
                end
            end
            OP_LOOKUP: begin
                if (hit) begin
                    o_dec.rd_en = 1'b1;
                end else begin
                    o_dec.status = ST_NOT_OPEN;
                end
            end
            OP_ADD_USER: begin
                if (r_users != 8'hFF) begin
                    n_users = r_users + 8'd1;
                end
            end
            OP_DEL_USER: begin
                if (r_users != 8'h00) begin
                    n_users = r_users - 8'd1;
                end
            end
            default: begin
            end
        endcase
        o_dec.users = n_users;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= SLOT_COUNT'((1 << HAT_PRESET_SLOTS) - 1);
            r_users <= '0;
        end else if (i_accept) begin
            r_valid <= n_valid;
            r_users <= n_users;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/hat_desc_mem.sv -----
// Descriptor memory with registered read and preset low slots.
`default_nettype none
module hat_desc_mem #(
    parameter int SLOT_COUNT = 32,
    parameter int SW         = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire logic          i_rd_en,
    input  wire logic [SW-1:0] i_addr,
    input  wire logic [15:0]   i_wr_data,
    output logic [15:0]        o_rd_data
);
    import hat_pkg::*;

    logic [15:0]                 r_mem [SLOT_COUNT];
    logic [15:0]                 r_rd_data;
    logic [HAT_PRESET_SLOTS-1:0] r_written;
    logic                        r_rd_preset;
    logic [1:0]                  r_rd_low;
    logic                        low_addr;
    logic                        low_written;
    logic [1:0]                  addr_low;

    assign addr_low = i_addr[1:0];
    assign low_addr = i_addr < SW'(HAT_PRESET_SLOTS);

    always_comb begin
        unique case (addr_low)
            2'd0:    low_written = r_written[0];
            2'd1:    low_written = r_written[1];
            2'd2:    low_written = r_written[2];
            default: low_written = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
            r_rd_low  <= addr_low;
        end
    end

    // Track which preset slots have been overwritten since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written   <= '0;
            r_rd_preset <= 1'b0;
        end else begin
            if (i_wr_en && low_addr) begin
                r_written[addr_low] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_preset <= low_addr && !low_written;
            end
        end
    end

    assign o_rd_data = r_rd_preset ? 16'(r_rd_low) : r_rd_data;

endmodule
`default_nettype wire

// ----- dv/handle_allocation_table_tb.sv -----
// Self-checking testbench for the handle allocation table: directed and random requests.
module handle_allocation_table_tb;
    import hat_pkg::*;

    localparam int SLOT_COUNT   = HAT_SLOT_COUNT;
    localparam int SW           = $clog2(SLOT_COUNT);
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;  // ~1820 transfers, many times over
    localparam int DRAIN_CYCLES = 8;       // result is registered through r_pend and r_done after the transfer
    localparam int REPORT_LIMIT = 10;
    localparam int GAP_PERCENT  = 17;

    // Operation codes the block does not decode; they must leave the state alone.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_hat_req i_req;
    logic     o_done;
    t_hat_rsp o_rsp;

    handle_allocation_table #(
        .SLOT_COUNT(SLOT_COUNT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    // Mirror of the table: valid bitmap, stored descriptors and the user count.
    logic [SLOT_COUNT-1:0] slot_open;
    logic [15:0]           slot_desc [SLOT_COUNT];
    logic [7:0]            attached_users;

    t_hat_rsp pending_rsp[$];   // responses owed by the block, oldest first

    int xfer_count;
    int rsp_count;
    int fail_count;
    int cycle_count;
    int full_hits;
    int not_open_hits;
    int top_hits;
    int bottom_hits;
    bit gaps_on;

    initial begin
        i_clk = 1'b0;
    end

    always #HALF_PERIOD i_clk = ~i_clk;

    // Seed the mirror with the post-reset table: three preset slots, no users.
    function automatic void reset_table_mirror();
        slot_open      = '0;
        attached_users = '0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_desc[s] = '0;
        end
        for (int s = 0; s < HAT_PRESET_SLOTS; s++) begin
            slot_open[s] = 1'b1;
            slot_desc[s] = 16'(s);
        end
    endfunction

    // Work out the response to one request and advance the mirror.
    function automatic t_hat_rsp predict_response(t_hat_req req);
        t_hat_rsp      rsp;
        bit            granted;
        bit            is_open;
        logic [SW-1:0] slot_idx;
        rsp      = '0;
        granted  = 1'b0;
        slot_idx = req.slot_handle[SW-1:0];
        is_open  = (req.slot_handle < SLOT_COUNT) && slot_open[slot_idx];
        rsp.status = ST_OK;
        case (req.operation)
            OP_OPEN: begin
                // Take the lowest free slot, or report the table full.
                rsp.status = ST_FULL;
                for (int s = 0; s < SLOT_COUNT; s++) begin
                    if (!granted && !slot_open[s]) begin
                        granted            = 1'b1;
                        slot_open[s]       = 1'b1;
                        slot_desc[s]       = req.external_descriptor;
                        rsp.granted_handle = 5'(s);
                        rsp.status         = ST_OK;
                    end
                end
                if (!granted) full_hits++;
            end
            OP_CLOSE: begin
                // Drop only the valid bit; the old descriptor stays but is unreachable.
                if (is_open) begin
                    slot_open[slot_idx] = 1'b0;
                end else begin
                    rsp.status = ST_NOT_OPEN;
                    not_open_hits++;
                end
            end
            OP_LOOKUP: begin
                if (is_open) begin
                    rsp.found_descriptor = slot_desc[slot_idx];
                end else begin
                    rsp.status = ST_NOT_OPEN;
                    not_open_hits++;
                end
            end
            OP_ADD_USER: begin
                if (attached_users == 8'hFF) top_hits++;
                else attached_users = attached_users + 8'd1;
            end
            OP_DEL_USER: begin
                if (attached_users == 8'h00) bottom_hits++;
                else attached_users = attached_users - 8'd1;
            end
            default: begin
                // Unused codes: no state change, status ok.
            end
        endcase
        rsp.user_count = attached_users;
        return rsp;
    endfunction

    // Record each transfer and check each result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                rsp_count++;
                if (pending_rsp.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("[%0d] unexpected result: st=%0d grant=%0d desc=%h users=%0d",
                                 cycle_count, o_rsp.status, o_rsp.granted_handle,
                                 o_rsp.found_descriptor, o_rsp.user_count);
                    end
                end else begin
                    t_hat_rsp expected;
                    expected = pending_rsp.pop_front();
                    if (o_rsp.status !== expected.status
                        || o_rsp.granted_handle !== expected.granted_handle
                        || o_rsp.found_descriptor !== expected.found_descriptor
                        || o_rsp.user_count !== expected.user_count) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("[%0d] mismatch: exp st=%0d grant=%0d desc=%h users=%0d",
                                     cycle_count, expected.status, expected.granted_handle,
                                     expected.found_descriptor, expected.user_count);
                            $display("[%0d]           got st=%0d grant=%0d desc=%h users=%0d",
                                     cycle_count, o_rsp.status, o_rsp.granted_handle,
                                     o_rsp.found_descriptor, o_rsp.user_count);
                        end
                    end
                end
            end
            // Predict after checking so a same-edge transfer never reorders the queue.
            if (start && !busy) begin
                pending_rsp.push_back(predict_response(i_req));
                xfer_count++;
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_rsp.size());
            $display("handle_allocation_table_tb NOT OK");
            $finish;
        end
    end

    // Hold start low with junk on the request bus.
    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start                     = 1'b0;
            i_req.operation           = 3'($urandom);
            i_req.slot_handle         = 8'($urandom);
            i_req.external_descriptor = 16'($urandom);
        end
    endtask

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic [2:0] op, input logic [7:0] handle,
                                input logic [15:0] desc);
        int target;
        if (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
            idle_cycles($urandom_range(1, 3));
        end
        target = xfer_count + 1;
        @(negedge i_clk);
        start                     = 1'b1;
        i_req.operation           = op;
        i_req.slot_handle         = handle;
        i_req.external_descriptor = desc;
        // Wait for the monitor so the mirror is current before the next pick.
        wait (xfer_count == target);
    endtask

    // Choose a handle: mostly an open slot, else in range, else anywhere.
    function automatic logic [7:0] pick_handle();
        int          roll;
        int          base;
        logic [7:0]  handle;
        bit          hit;
        roll   = $urandom_range(99);
        handle = 8'($urandom_range(255));
        hit    = 1'b0;
        if (roll < 65) begin
            base = $urandom_range(SLOT_COUNT - 1);
            for (int k = 0; k < SLOT_COUNT; k++) begin
                if (!hit && slot_open[SW'((base + k) % SLOT_COUNT)]) begin
                    hit    = 1'b1;
                    handle = 8'((base + k) % SLOT_COUNT);
                end
            end
        end else if (roll < 90) begin
            handle = 8'($urandom_range(SLOT_COUNT - 1));
        end
        return handle;
    endfunction

    // Preset slots, free and out-of-range handles, unused codes.
    task automatic test_preset_slots();
        for (int s = 0; s < HAT_PRESET_SLOTS; s++) begin
            send_request(OP_LOOKUP, 8'(s), 16'($urandom));
        end
        send_request(OP_LOOKUP, 8'(HAT_PRESET_SLOTS), 16'hFFFF);
        send_request(OP_LOOKUP, 8'(SLOT_COUNT), 16'h0000);
        send_request(OP_LOOKUP, 8'hFF, 16'($urandom));
        send_request(OP_CLOSE, 8'(HAT_PRESET_SLOTS), 16'($urandom));
        send_request(OP_CLOSE, 8'hFF, 16'($urandom));
        for (logic [3:0] op = {1'b0, OP_SPARE_FIRST}; op <= {1'b0, OP_SPARE_LAST}; op++) begin
            send_request(op[2:0], 8'($urandom), 16'($urandom));
        end
    endtask

    // Fill every slot, overflow, then free a few and check lowest-free order.
    task automatic test_fill_and_full();
        send_request(OP_OPEN, 8'h00, 16'hFFFF);
        send_request(OP_OPEN, 8'hFF, 16'h0000);
        while (slot_open != '1) begin
            send_request(OP_OPEN, 8'($urandom), 16'($urandom));
        end
        send_request(OP_OPEN, 8'($urandom), 16'hFFFF);
        send_request(OP_LOOKUP, 8'(SLOT_COUNT - 1), 16'($urandom));
        send_request(OP_CLOSE, 8'(SLOT_COUNT - 1), 16'($urandom));
        send_request(OP_CLOSE, 8'h00, 16'($urandom));
        send_request(OP_CLOSE, 8'(SLOT_COUNT / 2), 16'($urandom));
        send_request(OP_LOOKUP, 8'(SLOT_COUNT - 1), 16'($urandom));
        send_request(OP_CLOSE, 8'(SLOT_COUNT - 1), 16'($urandom));
        send_request(OP_OPEN, 8'($urandom), 16'hA5A5);
        send_request(OP_OPEN, 8'($urandom), 16'h5A5A);
        send_request(OP_OPEN, 8'($urandom), 16'h8001);
        send_request(OP_OPEN, 8'($urandom), 16'($urandom));
        send_request(OP_LOOKUP, 8'(SLOT_COUNT - 1), 16'($urandom));
        send_request(OP_LOOKUP, 8'h00, 16'($urandom));
    endtask

    // Walk the user count past both saturation points.
    task automatic test_user_count();
        send_request(OP_DEL_USER, 8'($urandom), 16'($urandom));
        repeat (258) send_request(OP_ADD_USER, 8'($urandom), 16'($urandom));
        repeat (258) send_request(OP_DEL_USER, 8'($urandom), 16'($urandom));
    endtask

    // Mixed traffic in alternating fill and drain epochs, with one gap-free stretch.
    task automatic test_random_traffic(input int count);
        int         roll;
        bit         filling;
        int         open_w;
        int         close_w;
        logic [2:0] op;
        for (int n = 0; n < count; n++) begin
            filling = ((n / 100) % 2) == 0;
            open_w  = filling ? 45 : 15;
            close_w = filling ? 15 : 45;
            gaps_on = !(n >= 500 && n < 800);
            roll    = $urandom_range(99);
            if (roll < open_w) op = OP_OPEN;
            else if (roll < open_w + close_w) op = OP_CLOSE;
            else if (roll < 85) op = OP_LOOKUP;
            else if (roll < 91) op = OP_ADD_USER;
            else if (roll < 97) op = OP_DEL_USER;
            else op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            send_request(op, pick_handle(), 16'($urandom));
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        start       = 1'b0;
        i_req       = '0;
        i_rst_n     = 1'b0;
        gaps_on     = 1'b1;
        xfer_count  = 0;
        rsp_count   = 0;
        fail_count  = 0;
        cycle_count = 0;
        full_hits   = 0;
        not_open_hits = 0;
        top_hits    = 0;
        bottom_hits = 0;
        reset_table_mirror();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_preset_slots();
        test_fill_and_full();
        test_user_count();
        test_random_traffic(1250);

        idle_cycles(1);
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d transfers, %0d results; table full %0d, not open %0d",
                 xfer_count, rsp_count, full_hits, not_open_hits);
        $display("user count held at top %0d times, at zero %0d times; %0d mismatches",
                 top_hits, bottom_hits, fail_count);
        if (fail_count == 0 && pending_rsp.size() == 0) begin
            $display("handle_allocation_table_tb OK");
        end else begin
            $display("handle_allocation_table_tb NOT OK");
        end
        $finish;
    end

endmodule
